### hdl/mfbrf_pkg.sv
// Shared constants, codes, types and helper functions of the monochrome frame fill engine.
package mfbrf_pkg;

  // Screen geometry and frame store sizing.
  localparam int SCREEN_WIDTH  = 200;
  localparam int SCREEN_HEIGHT = 200;
  localparam int PIX_COUNT     = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int STORE_BYTES   = (PIX_COUNT + 7) / 8;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int PIX_W         = $clog2(PIX_COUNT);
  localparam int X_W           = $clog2(SCREEN_WIDTH);
  localparam int Y_W           = $clog2(SCREEN_HEIGHT + 1);

  // Field widths of the command and response channels.
  localparam int KIND_W    = 2;
  localparam int POS_W     = 11;
  localparam int SIZE_W    = 10;
  localparam int BADDR_W   = 13;
  localparam int DATA_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CLIP_W    = 8;

  // Signed working width of rectangle edges, wide enough for position plus size.
  localparam int COORD_W = 13;

  // Command kinds.
  localparam logic [KIND_W-1:0] KIND_FILL    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OUTLINE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ON     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 3'd4;

  // Byte constants.
  localparam logic [DATA_W-1:0] PIX_MSB         = 8'h80;
  localparam logic [DATA_W-1:0] BYTE_WHITE      = 8'hFF;
  localparam logic [DATA_W-1:0] BYTE_ZERO       = 8'h00;
  localparam logic [CLIP_W-1:0] CLIP_SIZE_RESET = 8'd200;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One pixel visit produced by the raster walker.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] mask;
  } walk_pix_t;

  // Clipped, non-empty segment handed to the raster walker (inclusive bounds).
  typedef struct packed {
    logic [X_W-1:0]   lo_x;
    logic [X_W-1:0]   hi_x;
    logic [Y_W-1:0]   lo_y;
    logic [Y_W-1:0]   hi_y;
    logic [PIX_W-1:0] base;
  } walk_seg_t;

  // Access request to the frame store: read, optionally followed by a masked write.
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic              black;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] mask;
  } store_req_t;

  function automatic coord_t coord_max(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t coord_min(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

### hdl/mfbrf_ifs.sv
// Handshake interfaces for the command, response and configuration channels.
interface mfbrf_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [mfbrf_pkg::KIND_W-1:0]         kind;
  logic signed [mfbrf_pkg::POS_W-1:0]   x_pos;
  logic signed [mfbrf_pkg::POS_W-1:0]   y_pos;
  logic [mfbrf_pkg::SIZE_W-1:0]         rect_width;
  logic [mfbrf_pkg::SIZE_W-1:0]         rect_height;
  logic                                 ink_black;
  logic [mfbrf_pkg::BADDR_W-1:0]        byte_address;

  modport source (
    output valid, kind, x_pos, y_pos, rect_width, rect_height, ink_black, byte_address,
    input  ready
  );
  modport sink (
    input  valid, kind, x_pos, y_pos, rect_width, rect_height, ink_black, byte_address,
    output ready
  );
endinterface

interface mfbrf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mfbrf_pkg::DATA_W-1:0]  read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

interface mfbrf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mfbrf_pkg::CFG_IDX_W-1:0]  index;
  logic [mfbrf_pkg::CLIP_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/mfbrf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module mfbrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a read of the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/mfbrf_walk.sv
// Raster walker that steps one pixel per cycle across a clipped segment.
module mfbrf_walk (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  mfbrf_pkg::walk_seg_t  seg,
  output mfbrf_pkg::walk_pix_t  pix,
  output logic                  busy
);

  localparam logic [mfbrf_pkg::PIX_W-1:0] ROW_STEP =
    mfbrf_pkg::PIX_W'(mfbrf_pkg::SCREEN_WIDTH);

  logic                          active;
  logic [mfbrf_pkg::X_W-1:0]     cur_x;
  logic [mfbrf_pkg::Y_W-1:0]     cur_y;
  logic [mfbrf_pkg::X_W-1:0]     lo_x;
  logic [mfbrf_pkg::X_W-1:0]     hi_x;
  logic [mfbrf_pkg::Y_W-1:0]     hi_y;
  logic [mfbrf_pkg::PIX_W-1:0]   pix_n;
  logic [mfbrf_pkg::PIX_W-1:0]   row_n;
  logic                          last_x;
  logic                          last_y;

  assign last_x = (cur_x == hi_x);
  assign last_y = (cur_y == hi_y);

  // The walk runs from start until the last column of the last row.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
    end else if (active && last_x && last_y) begin
      active <= 1'b0;
    end
  end

  // Column and row stepping with an incremental pixel number.
  always_ff @(posedge clk) begin
    if (start) begin
      cur_x <= seg.lo_x;
      cur_y <= seg.lo_y;
      lo_x  <= seg.lo_x;
      hi_x  <= seg.hi_x;
      hi_y  <= seg.hi_y;
      pix_n <= seg.base;
      row_n <= seg.base;
    end else if (active) begin
      if (!last_x) begin
        cur_x <= cur_x + 1'b1;
        pix_n <= pix_n + 1'b1;
      end else begin
        cur_x <= lo_x;
        cur_y <= cur_y + 1'b1;
        row_n <= row_n + ROW_STEP;
        pix_n <= row_n + ROW_STEP;
      end
    end
  end

  // Byte address and MSB-first bit mask of the current pixel.
  always_comb begin
    pix.valid = active;
    pix.addr  = mfbrf_pkg::ADDR_W'(pix_n >> 3);
    pix.mask  = mfbrf_pkg::PIX_MSB >> pix_n[2:0];
  end

  assign busy = active;

endmodule

### hdl/mfbrf_store.sv
// Frame store with read-modify-write pipeline, forwarding and a clear write path.
module mfbrf_store (
  input  logic                               clk,
  input  logic                               rst,
  input  mfbrf_pkg::store_req_t              req,
  input  logic                               clr_en,
  input  logic [mfbrf_pkg::ADDR_W-1:0]       clr_addr,
  output logic [mfbrf_pkg::DATA_W-1:0]       rdata
);

  logic                              s2_wr;
  logic                              s2_black;
  logic [mfbrf_pkg::ADDR_W-1:0]      s2_addr;
  logic [mfbrf_pkg::DATA_W-1:0]      s2_mask;
  logic                              hold_valid;
  logic [mfbrf_pkg::ADDR_W-1:0]      hold_addr;
  logic [mfbrf_pkg::DATA_W-1:0]      hold_data;
  logic [mfbrf_pkg::DATA_W-1:0]      ram_rdata;
  logic [mfbrf_pkg::DATA_W-1:0]      base;
  logic [mfbrf_pkg::DATA_W-1:0]      merged;
  logic                              wr_en;
  logic [mfbrf_pkg::ADDR_W-1:0]      wr_addr;
  logic [mfbrf_pkg::DATA_W-1:0]      wr_data;

  // Modify stage control, registered behind the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_wr      <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      s2_wr      <= req.wr;
      hold_valid <= s2_wr;
    end
  end

  // Modify stage payload and the byte written in the previous cycle.
  always_ff @(posedge clk) begin
    s2_black  <= req.black;
    s2_addr   <= req.addr;
    s2_mask   <= req.mask;
    hold_addr <= s2_addr;
    hold_data <= merged;
  end

  // A byte written last cycle is newer than what the memory returned.
  assign base   = (hold_valid && (hold_addr == s2_addr)) ? hold_data : ram_rdata;
  assign merged = s2_black ? (base & ~s2_mask) : (base | s2_mask);

  // Clear sweeps and pixel write-backs never overlap.
  assign wr_en   = s2_wr || clr_en;
  assign wr_addr = clr_en ? clr_addr : s2_addr;
  assign wr_data = clr_en ? mfbrf_pkg::BYTE_WHITE : merged;
  assign rdata   = ram_rdata;

  mfbrf_ram #(
    .WIDTH (mfbrf_pkg::DATA_W),
    .DEPTH (mfbrf_pkg::STORE_BYTES)
  ) u_ram (
    .clk     (clk),
    .rd_en   (req.rd),
    .rd_addr (req.addr),
    .rd_data (ram_rdata),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // A clear write must never collide with a pixel write-back.
  assert property (@(posedge clk) disable iff (rst) !(clr_en && s2_wr))
    else $error("clear write collided with pixel write-back");

  // Pixel write-backs stay inside the frame store.
  assert property (@(posedge clk) disable iff (rst)
    s2_wr |-> (32'(s2_addr) < mfbrf_pkg::STORE_BYTES))
    else $error("pixel write-back beyond frame store");

endmodule

### hdl/mono_framebuffer_rect_fill_clip_core.sv
// Top level of the monochrome frame fill engine: command sequencing, clipping, configuration.
// Command flow after acceptance: fill has 1 segment, outline 4; each segment passes the setup
//   and bound states and, if any pixel is visible, the walk state; an in-range read passes the
//   read and read-wait states, a clear sweeps all STORE_BYTES bytes; all end in the done state.
// Throughput: one command at a time, one pixel per cycle; an untaken result stalls the next.
// Reset: a clearing pass over all STORE_BYTES bytes whitens the store; commands wait, config does not.
module mono_framebuffer_rect_fill_clip_core (
  input  logic         clk,
  input  logic         rst,
  mfbrf_cmd_if.sink    cmd,
  mfbrf_rsp_if.source  rsp,
  mfbrf_cfg_if.sink    cfg
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SETUP  = 3'd2;
  localparam logic [2:0] ST_BOUND  = 3'd3;
  localparam logic [2:0] ST_WALK   = 3'd4;
  localparam logic [2:0] ST_READ   = 3'd5;
  localparam logic [2:0] ST_RDWAIT = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  // Outline segments: top row, bottom row, left column, right column.
  localparam logic [1:0] SEG_TOP    = 2'd0;
  localparam logic [1:0] SEG_BOTTOM = 2'd1;
  localparam logic [1:0] SEG_LEFT   = 2'd2;
  localparam logic [1:0] SEG_RIGHT  = 2'd3;

  localparam mfbrf_pkg::coord_t COORD_ONE  = mfbrf_pkg::COORD_W'(1);
  localparam mfbrf_pkg::coord_t COORD_ZERO = mfbrf_pkg::COORD_W'(0);
  localparam mfbrf_pkg::coord_t SCR_W      = mfbrf_pkg::COORD_W'(mfbrf_pkg::SCREEN_WIDTH);
  localparam mfbrf_pkg::coord_t SCR_H      = mfbrf_pkg::COORD_W'(mfbrf_pkg::SCREEN_HEIGHT);
  localparam logic [mfbrf_pkg::ADDR_W-1:0] CLR_LAST =
    mfbrf_pkg::ADDR_W'(mfbrf_pkg::STORE_BYTES - 1);

  logic [2:0]                          state;
  logic                                clr_cmd;
  logic [mfbrf_pkg::ADDR_W-1:0]        clr_addr;
  logic [1:0]                          seg_idx;
  logic [1:0]                          seg_last;

  // Latched command.
  logic [mfbrf_pkg::KIND_W-1:0]        cmd_kind;
  logic signed [mfbrf_pkg::POS_W-1:0]  cmd_x;
  logic signed [mfbrf_pkg::POS_W-1:0]  cmd_y;
  logic [mfbrf_pkg::SIZE_W-1:0]        cmd_w;
  logic [mfbrf_pkg::SIZE_W-1:0]        cmd_h;
  logic                                cmd_black;
  logic [mfbrf_pkg::BADDR_W-1:0]       cmd_addr;
  logic [mfbrf_pkg::DATA_W-1:0]        res_data;

  // Configuration registers.
  logic                                clip_on;
  logic [mfbrf_pkg::CLIP_W-1:0]        clip_left;
  logic [mfbrf_pkg::CLIP_W-1:0]        clip_top;
  logic [mfbrf_pkg::CLIP_W-1:0]        clip_width;
  logic [mfbrf_pkg::CLIP_W-1:0]        clip_height;

  // Output register.
  logic                                out_valid;
  logic [mfbrf_pkg::DATA_W-1:0]        out_data;
  logic                                res_fire;

  // Segment geometry.
  mfbrf_pkg::coord_t xs, ys, ws, hs;
  mfbrf_pkg::coord_t seg_l, seg_r, seg_t, seg_b;
  mfbrf_pkg::coord_t win_l, win_r, win_t, win_b;
  mfbrf_pkg::coord_t bx_lo, bx_hi, by_lo, by_hi;
  mfbrf_pkg::coord_t bx_last, by_last;
  logic                                seg_empty;

  mfbrf_pkg::walk_seg_t                walk_seg;
  mfbrf_pkg::walk_pix_t                walk_pix;
  logic                                walk_start;
  logic                                walk_busy;
  mfbrf_pkg::store_req_t               store_req;
  logic [mfbrf_pkg::DATA_W-1:0]        store_rdata;
  logic                                cmd_accept;

  assign cmd.ready  = (state == ST_IDLE);
  assign cmd_accept = cmd.valid && cmd.ready;
  assign cfg.ready  = 1'b1;
  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;

  // The finished command hands its result over once the output register is free.
  assign res_fire = (state == ST_DONE) && (!out_valid || rsp.ready);

  // Configuration writes; indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_on     <= 1'b0;
      clip_left   <= '0;
      clip_top    <= '0;
      clip_width  <= mfbrf_pkg::CLIP_SIZE_RESET;
      clip_height <= mfbrf_pkg::CLIP_SIZE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        mfbrf_pkg::CFG_CLIP_ON:     clip_on     <= cfg.data[0];
        mfbrf_pkg::CFG_CLIP_LEFT:   clip_left   <= cfg.data;
        mfbrf_pkg::CFG_CLIP_TOP:    clip_top    <= cfg.data;
        mfbrf_pkg::CFG_CLIP_WIDTH:  clip_width  <= cfg.data;
        mfbrf_pkg::CFG_CLIP_HEIGHT: clip_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Edges of the current segment, right and bottom exclusive.
  always_comb begin
    xs = mfbrf_pkg::COORD_W'(cmd_x);
    ys = mfbrf_pkg::COORD_W'(cmd_y);
    ws = mfbrf_pkg::COORD_W'(cmd_w);
    hs = mfbrf_pkg::COORD_W'(cmd_h);
    seg_l = xs;
    seg_r = xs + ws;
    seg_t = ys;
    seg_b = ys + hs;
    if (cmd_kind == mfbrf_pkg::KIND_OUTLINE) begin
      case (seg_idx)
        SEG_TOP:    seg_b = ys + COORD_ONE;
        SEG_BOTTOM: seg_t = ys + hs - COORD_ONE;
        SEG_LEFT:   seg_r = xs + COORD_ONE;
        default:    seg_l = xs + ws - COORD_ONE;
      endcase
    end
  end

  // Visible window: the screen, narrowed by the clip window when enabled.
  always_comb begin
    if (clip_on) begin
      win_l = mfbrf_pkg::COORD_W'(clip_left);
      win_t = mfbrf_pkg::COORD_W'(clip_top);
      win_r = mfbrf_pkg::coord_min(
        mfbrf_pkg::COORD_W'(9'(clip_left) + 9'(clip_width)), SCR_W);
      win_b = mfbrf_pkg::coord_min(
        mfbrf_pkg::COORD_W'(9'(clip_top) + 9'(clip_height)), SCR_H);
    end else begin
      win_l = COORD_ZERO;
      win_t = COORD_ZERO;
      win_r = SCR_W;
      win_b = SCR_H;
    end
  end

  // Clipped bounds of the registered segment and the walker's view of them.
  assign seg_empty = (bx_lo >= bx_hi) || (by_lo >= by_hi);
  assign bx_last   = bx_hi - COORD_ONE;
  assign by_last   = by_hi - COORD_ONE;
  assign seg_last  = (cmd_kind == mfbrf_pkg::KIND_OUTLINE) ? SEG_RIGHT : SEG_TOP;
  assign walk_start = (state == ST_BOUND) && !seg_empty;

  always_comb begin
    walk_seg.lo_x = bx_lo[mfbrf_pkg::X_W-1:0];
    walk_seg.hi_x = bx_last[mfbrf_pkg::X_W-1:0];
    walk_seg.lo_y = by_lo[mfbrf_pkg::Y_W-1:0];
    walk_seg.hi_y = by_last[mfbrf_pkg::Y_W-1:0];
    walk_seg.base = mfbrf_pkg::PIX_W'(by_lo[mfbrf_pkg::Y_W-1:0])
                  * mfbrf_pkg::PIX_W'(mfbrf_pkg::SCREEN_WIDTH)
                  + mfbrf_pkg::PIX_W'(bx_lo[mfbrf_pkg::X_W-1:0]);
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cmd   <= 1'b0;
      clr_addr  <= '0;
      seg_idx   <= SEG_TOP;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clr_addr == CLR_LAST) begin
            clr_addr <= '0;
            state    <= clr_cmd ? ST_DONE : ST_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (cmd_accept) begin
            seg_idx <= SEG_TOP;
            case (cmd.kind)
              mfbrf_pkg::KIND_FILL,
              mfbrf_pkg::KIND_OUTLINE: state <= ST_SETUP;
              mfbrf_pkg::KIND_READ: begin
                if (32'(cmd.byte_address) < 32'(mfbrf_pkg::STORE_BYTES)) begin
                  state <= ST_READ;
                end else begin
                  state <= ST_DONE;
                end
              end
              default: begin
                clr_cmd <= 1'b1;
                state   <= ST_CLEAR;
              end
            endcase
          end
        end
        ST_SETUP: state <= ST_BOUND;
        ST_BOUND: begin
          if (!seg_empty) begin
            state <= ST_WALK;
          end else if (seg_idx == seg_last) begin
            state <= ST_DONE;
          end else begin
            seg_idx <= seg_idx + 1'b1;
            state   <= ST_SETUP;
          end
        end
        ST_WALK: begin
          if (!walk_busy) begin
            if (seg_idx == seg_last) begin
              state <= ST_DONE;
            end else begin
              seg_idx <= seg_idx + 1'b1;
              state   <= ST_SETUP;
            end
          end
        end
        ST_READ:   state <= ST_RDWAIT;
        ST_RDWAIT: state <= ST_DONE;
        default: begin
          if (res_fire) begin
            clr_cmd <= 1'b0;
            state   <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // Result valid: set as a command completes, cleared when the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Command payload, clipped bounds and result data.
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      cmd_kind  <= cmd.kind;
      cmd_x     <= cmd.x_pos;
      cmd_y     <= cmd.y_pos;
      cmd_w     <= cmd.rect_width;
      cmd_h     <= cmd.rect_height;
      cmd_black <= cmd.ink_black;
      cmd_addr  <= cmd.byte_address;
      res_data  <= mfbrf_pkg::BYTE_ZERO;
    end
    if (state == ST_SETUP) begin
      bx_lo <= mfbrf_pkg::coord_max(seg_l, win_l);
      bx_hi <= mfbrf_pkg::coord_min(seg_r, win_r);
      by_lo <= mfbrf_pkg::coord_max(seg_t, win_t);
      by_hi <= mfbrf_pkg::coord_min(seg_b, win_b);
    end
    if (state == ST_RDWAIT) begin
      res_data <= store_rdata;
    end
    if (res_fire) begin
      out_data <= res_data;
    end
  end

  // Store access: walker pixels read-modify-write, a read command only reads.
  always_comb begin
    store_req.rd    = walk_pix.valid || (state == ST_READ);
    store_req.wr    = walk_pix.valid;
    store_req.black = cmd_black;
    store_req.addr  = walk_pix.valid ? walk_pix.addr : mfbrf_pkg::ADDR_W'(cmd_addr);
    store_req.mask  = walk_pix.mask;
  end

  mfbrf_walk u_walk (
    .clk   (clk),
    .rst   (rst),
    .start (walk_start),
    .seg   (walk_seg),
    .pix   (walk_pix),
    .busy  (walk_busy)
  );

  mfbrf_store u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (store_req),
    .clr_en   (state == ST_CLEAR),
    .clr_addr (clr_addr),
    .rdata    (store_rdata)
  );

  // The walker runs only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) walk_busy |-> (state == ST_WALK))
    else $error("raster walker active outside the walk state");

  // An accepted command always leaves the idle state.
  assert property (@(posedge clk) disable iff (rst) cmd_accept |=> (state != ST_IDLE))
    else $error("accepted command did not start");

  // A result appears only as a command completes.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside command completion");

endmodule

### sim/tb.sv
// Self-checking testbench of the monochrome frame fill engine with clipping.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfbrf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 500;
  localparam int PHASE_ITEMS = 100;

  // One drawing command as it crosses the command channel.
  typedef struct {
    bit [KIND_W-1:0]         kind;
    bit signed [POS_W-1:0]   x_pos;
    bit signed [POS_W-1:0]   y_pos;
    bit [SIZE_W-1:0]         rect_width;
    bit [SIZE_W-1:0]         rect_height;
    bit                      ink_black;
    bit [BADDR_W-1:0]        byte_address;
  } draw_cmd_t;

  // Tracks the frame store and clip window, and holds the response bytes still due.
  class raster_tracker;
    bit [DATA_W-1:0] pix_bytes [STORE_BYTES];
    bit              clip_on;
    int              clip_left;
    int              clip_top;
    int              clip_width;
    int              clip_height;
    bit [DATA_W-1:0] due_bytes [$];
    int              failures;
    int              checked;

    function new();
      foreach (pix_bytes[i]) pix_bytes[i] = BYTE_WHITE;
      clip_on = 1'b0;
      clip_left = 0;
      clip_top = 0;
      clip_width = SCREEN_WIDTH;
      clip_height = SCREEN_HEIGHT;
      failures = 0;
      checked = 0;
    endfunction

    function void set_clip(logic [CFG_IDX_W-1:0] idx, bit [CLIP_W-1:0] val);
      case (idx)
        CFG_CLIP_ON:     clip_on = val[0];
        CFG_CLIP_LEFT:   clip_left = int'(val);
        CFG_CLIP_TOP:    clip_top = int'(val);
        CFG_CLIP_WIDTH:  clip_width = int'(val);
        CFG_CLIP_HEIGHT: clip_height = int'(val);
        default: ;
      endcase
    endfunction

    // A pixel lands only on screen and, when clipping is on, inside the window.
    function void plot(int px, int py, bit black);
      int n;
      int idx;
      bit [DATA_W-1:0] mask;
      if (px < 0 || py < 0 || px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT) return;
      if (clip_on && (px < clip_left || py < clip_top ||
                      px >= clip_left + clip_width || py >= clip_top + clip_height)) return;
      n = SCREEN_WIDTH * py + px;
      idx = n / 8;
      if (idx >= STORE_BYTES) return;
      mask = PIX_MSB >> (n % 8);
      if (black) pix_bytes[idx] = pix_bytes[idx] & ~mask;
      else pix_bytes[idx] = pix_bytes[idx] | mask;
    endfunction

    function void paint_area(int x, int y, int w, int h, bit black);
      int x0;
      int y0;
      int x1;
      int y1;
      x0 = (x < 0) ? 0 : x;
      y0 = (y < 0) ? 0 : y;
      x1 = (x + w > SCREEN_WIDTH) ? SCREEN_WIDTH : x + w;
      y1 = (y + h > SCREEN_HEIGHT) ? SCREEN_HEIGHT : y + h;
      for (int yy = y0; yy < y1; yy++)
        for (int xx = x0; xx < x1; xx++)
          plot(xx, yy, black);
    endfunction

    // Applies an accepted command and queues the byte its response must carry.
    function void take_command(draw_cmd_t c);
      int x;
      int y;
      int w;
      int h;
      bit [DATA_W-1:0] data;
      x = int'(c.x_pos);
      y = int'(c.y_pos);
      w = int'(c.rect_width);
      h = int'(c.rect_height);
      data = BYTE_ZERO;
      case (c.kind)
        KIND_FILL: paint_area(x, y, w, h, c.ink_black);
        KIND_OUTLINE: begin
          paint_area(x, y, w, 1, c.ink_black);
          paint_area(x, y + h - 1, w, 1, c.ink_black);
          paint_area(x, y, 1, h, c.ink_black);
          paint_area(x + w - 1, y, 1, h, c.ink_black);
        end
        KIND_READ: begin
          if (int'(c.byte_address) < STORE_BYTES) data = pix_bytes[c.byte_address];
        end
        default: begin
          foreach (pix_bytes[i]) pix_bytes[i] = BYTE_WHITE;
        end
      endcase
      due_bytes.push_back(data);
    endfunction

    task report(string msg);
      failures++;
      if (failures <= 40) $display("tb: mismatch: %s", msg);
    endtask

    // Compares one response transaction with the oldest byte due.
    task check_response(logic [DATA_W-1:0] got);
      bit [DATA_W-1:0] want;
      if (due_bytes.size() == 0) begin
        report($sformatf("response %02h with no command outstanding", got));
      end else begin
        want = due_bytes.pop_front();
        if (got !== want)
          report($sformatf("response %0d: read_data %02h, expected %02h", checked, got, want));
      end
      checked++;
    endtask

    function int pending();
      return due_bytes.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady;
  bit   hold_request;
  int   last_x;
  int   last_y;
  int   last_w;
  int   last_h;

  raster_tracker sb = new();

  mfbrf_cmd_if cmd ();
  mfbrf_rsp_if rsp ();
  mfbrf_cfg_if cfg ();

  mono_framebuffer_rect_fill_clip_core i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp),
    .cfg (cfg)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // Response side: checks each transaction and stalls at random or on request.
  initial begin
    int hold_left;
    hold_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) sb.check_response(rsp.read_data);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (steady) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(99) >= 27);
      end
    end
  end

  function automatic draw_cmd_t mk(bit [KIND_W-1:0] kind, int x, int y, int w, int h,
                                   bit black, int addr);
    draw_cmd_t c;
    c.kind = kind;
    c.x_pos = x[POS_W-1:0];
    c.y_pos = y[POS_W-1:0];
    c.rect_width = w[SIZE_W-1:0];
    c.rect_height = h[SIZE_W-1:0];
    c.ink_black = black;
    c.byte_address = addr[BADDR_W-1:0];
    return c;
  endfunction

  // Read addresses mostly land near the last drawn rectangle so that drawing is observed.
  function automatic bit [BADDR_W-1:0] pick_addr();
    int px;
    int py;
    int a;
    if ($urandom_range(99) < 70) begin
      px = last_x + int'($urandom_range(0, (last_w > 40 ? 40 : last_w) + 1)) - 1;
      py = last_y + int'($urandom_range(0, (last_h > 40 ? 40 : last_h) + 1)) - 1;
      px = (px < 0) ? 0 : (px >= SCREEN_WIDTH) ? SCREEN_WIDTH - 1 : px;
      py = (py < 0) ? 0 : (py >= SCREEN_HEIGHT) ? SCREEN_HEIGHT - 1 : py;
      a = (SCREEN_WIDTH * py + px) / 8;
    end else begin
      a = $urandom_range(0, STORE_BYTES - 1);
    end
    return a[BADDR_W-1:0];
  endfunction

  // Random command: mostly small rectangles near the screen, some far off with one
  // thin dimension so that the pixel count stays bounded.
  function automatic draw_cmd_t next_random_cmd();
    draw_cmd_t c;
    bit [31:0] bits;
    int r;
    int g;
    int x;
    int y;
    int w;
    int h;
    bits = $urandom;
    c.x_pos = bits[10:0];
    c.y_pos = bits[21:11];
    bits = $urandom;
    c.rect_width = bits[9:0];
    c.rect_height = bits[19:10];
    c.ink_black = bits[20];
    c.byte_address = bits[31:19];
    r = $urandom_range(99);
    if (r < 38) c.kind = KIND_FILL;
    else if (r < 60) c.kind = KIND_OUTLINE;
    else if (r < 98) c.kind = KIND_READ;
    else c.kind = KIND_CLEAR;
    if (c.kind == KIND_FILL || c.kind == KIND_OUTLINE) begin
      g = $urandom_range(99);
      if (g < 70) begin
        x = int'($urandom_range(0, 215)) - 8;
        y = int'($urandom_range(0, 215)) - 8;
        w = $urandom_range(0, 24);
        h = $urandom_range(0, 24);
      end else if (g < 85) begin
        x = int'($urandom_range(0, 239)) - 40;
        y = int'($urandom_range(0, 239)) - 40;
        w = $urandom_range(0, 60);
        h = $urandom_range(0, 60);
      end else begin
        x = int'(c.x_pos);
        y = int'(c.y_pos);
        w = int'(c.rect_width);
        h = int'(c.rect_height);
        if (c.kind == KIND_FILL) begin
          if (bits[0]) h = $urandom_range(0, 3);
          else w = $urandom_range(0, 3);
        end
      end
      c.x_pos = x[POS_W-1:0];
      c.y_pos = y[POS_W-1:0];
      c.rect_width = w[SIZE_W-1:0];
      c.rect_height = h[SIZE_W-1:0];
      last_x = x;
      last_y = y;
      last_w = w;
      last_h = h;
    end else if (c.kind == KIND_READ && $urandom_range(99) < 85) begin
      c.byte_address = pick_addr();
    end
    return c;
  endfunction

  // Offers one command, with random idle cycles ahead of it unless steady, until a transaction occurs.
  task automatic send_cmd(draw_cmd_t c);
    if (!steady)
      while ($urandom_range(99) < 27) begin
        cmd.valid <= 1'b0;
        @(posedge clk);
      end
    cmd.valid <= 1'b1;
    cmd.kind <= c.kind;
    cmd.x_pos <= c.x_pos;
    cmd.y_pos <= c.y_pos;
    cmd.rect_width <= c.rect_width;
    cmd.rect_height <= c.rect_height;
    cmd.ink_black <= c.ink_black;
    cmd.byte_address <= c.byte_address;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    sb.take_command(c);
  endtask

  // Waits until every response due has arrived and the block has gone quiet.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_items(int n);
    repeat (n) send_cmd(next_random_cmd());
    cmd.valid <= 1'b0;
    drain();
  endtask

  // Register writes; valid is lowered once after the last one.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [CLIP_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    sb.set_clip(idx, val);
  endtask

  task automatic apply_clip(bit on, int left, int top, int w, int h);
    write_reg(CFG_CLIP_ON, {7'd0, on});
    write_reg(CFG_CLIP_LEFT, left[CLIP_W-1:0]);
    write_reg(CFG_CLIP_TOP, top[CLIP_W-1:0]);
    write_reg(CFG_CLIP_WIDTH, w[CLIP_W-1:0]);
    write_reg(CFG_CLIP_HEIGHT, h[CLIP_W-1:0]);
    cfg.valid <= 1'b0;
  endtask

  // Main sequence: reset, directed commands, then random phases under several clip settings.
  initial begin
    steady = 1'b0;
    hold_request = 1'b0;
    last_x = 0;
    last_y = 0;
    last_w = 8;
    last_h = 8;
    rst <= 1'b1;
    cmd.valid <= 1'b0;
    cmd.kind <= KIND_READ;
    cmd.x_pos <= '0;
    cmd.y_pos <= '0;
    cmd.rect_width <= '0;
    cmd.rect_height <= '0;
    cmd.ink_black <= 1'b0;
    cmd.byte_address <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= CFG_CLIP_ON;
    cfg.data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset state, store bounds and out-of-range reads.
    send_cmd(mk(KIND_READ, 0, 0, 0, 0, 1'b0, 0));
    send_cmd(mk(KIND_READ, 0, 0, 0, 0, 1'b0, STORE_BYTES - 1));
    send_cmd(mk(KIND_READ, 0, 0, 0, 0, 1'b0, STORE_BYTES));
    send_cmd(mk(KIND_READ, -1024, 1023, 1023, 1023, 1'b1, 8191));
    // Full-screen black, then a white pair of pixels, then a clear.
    send_cmd(mk(KIND_FILL, 0, 0, SCREEN_WIDTH, SCREEN_HEIGHT, 1'b1, 0));
    send_cmd(mk(KIND_FILL, 3, 0, 2, 1, 1'b0, 0));
    send_cmd(mk(KIND_READ, 0, 0, 0, 0, 1'b0, 0));
    send_cmd(mk(KIND_READ, 0, 0, 0, 0, 1'b0, STORE_BYTES - 1));
    send_cmd(mk(KIND_CLEAR, -1024, -1024, 1023, 1023, 1'b1, 8191));
    send_cmd(mk(KIND_FILL, 0, 0, 1, 1, 1'b1, 0));
    send_cmd(mk(KIND_READ, 0, 0, 0, 0, 1'b0, 0));
    // Rectangles entirely off screen and zero-sized fills draw nothing.
    send_cmd(mk(KIND_FILL, -1024, -1024, 1023, 1023, 1'b1, 0));
    send_cmd(mk(KIND_FILL, 1023, 1023, 1023, 1023, 1'b1, 0));
    send_cmd(mk(KIND_FILL, 12, 0, 0, 5, 1'b1, 0));
    // Degenerate outlines still draw two columns or two rows.
    send_cmd(mk(KIND_OUTLINE, 10, 0, 0, 3, 1'b1, 0));
    send_cmd(mk(KIND_OUTLINE, 20, 1, 5, 0, 1'b1, 0));
    send_cmd(mk(KIND_READ, 0, 0, 0, 0, 1'b0, 1));
    send_cmd(mk(KIND_READ, 0, 0, 0, 0, 1'b0, 2));
    send_cmd(mk(KIND_READ, 0, 0, 0, 0, 1'b0, 25));
    // Screen-sized outline and a fill clipped to the last pixel.
    send_cmd(mk(KIND_OUTLINE, 0, 0, SCREEN_WIDTH, SCREEN_HEIGHT, 1'b1, 0));
    send_cmd(mk(KIND_OUTLINE, -1024, -1024, 1023, 1023, 1'b1, 0));
    send_cmd(mk(KIND_READ, 0, 0, 0, 0, 1'b0, 49));
    send_cmd(mk(KIND_FILL, 199, 199, 1023, 1023, 1'b0, 0));
    send_cmd(mk(KIND_READ, 0, 0, 0, 0, 1'b0, STORE_BYTES - 1));
    send_cmd(mk(KIND_CLEAR, 0, 0, 0, 0, 1'b0, 0));
    run_items(PHASE_ITEMS);

    // Clip window phases; the second one starts with a long response stall.
    apply_clip(1'b1, 0, 0, SCREEN_WIDTH, SCREEN_HEIGHT);
    run_items(PHASE_ITEMS);
    apply_clip(1'b1, 50, 40, 60, 30);
    hold_request = 1'b1;
    run_items(PHASE_ITEMS);
    apply_clip(1'b1, 0, 0, 0, 0);
    run_items(PHASE_ITEMS);
    apply_clip(1'b1, 255, 255, 255, 255);
    run_items(PHASE_ITEMS);
    apply_clip(1'b1, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 255));
    run_items(PHASE_ITEMS);
    // A stretch with no idling on either side.
    steady = 1'b1;
    apply_clip(1'b0, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 255));
    run_items(PHASE_ITEMS);
    steady = 1'b0;
    apply_clip(1'b1, 190, 190, 10, 10);
    run_items(PHASE_ITEMS);
    apply_clip(1'b1, $urandom_range(0, 199), $urandom_range(0, 199),
               $urandom_range(1, 200), $urandom_range(1, 200));
    run_items(PHASE_ITEMS);
    apply_clip(1'b0, 0, 0, SCREEN_WIDTH, SCREEN_HEIGHT);
    run_items(PHASE_ITEMS);

    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
